>>> rtl/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg
// Types and constants shared by the indentation checker and its channels.
// ----------------------------------------------------------------------------
package irc_pkg;

	// text characters the checker reacts to
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// leading-space counter saturates here
	localparam logic [7:0] SPACE_SAT = 8'hFF;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_INDENT = 2'd1;
	localparam logic [1:0] ST_DEPTH  = 2'd2;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_LEADING = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  check_status;
		logic [15:0] error_line;
	} out_word_t;

endpackage

>>> rtl/irc_stream_if.sv
// ----------------------------------------------------------------------------
// irc_stream_if
// Valid/ready channel carrying one word of type word_t per handshake.
// ----------------------------------------------------------------------------
interface irc_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/indentation_rule_checker_top.sv
// ----------------------------------------------------------------------------
// indentation_rule_checker_top
// Streaming checker for Python-style indentation, one text byte per word.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle on the item channel and returns one
// result word (status, line of first error) when the byte flagged end_of_text
// has been processed; all other bytes produce no result. Each byte is captured
// in an input register, run through compare/increment logic that updates the
// scan state, and the result for the final byte is written from the input
// register into an output register. Sustained rate is one byte per cycle; the
// only stall is a result word still held in the output register when the next
// text ends, which holds that final byte in the input stage until the consumer
// takes the pending result. Leading spaces are counted
// together with a running level/remainder against INDENT_WIDTH, so no divider
// is needed. After each result all scan state returns to its reset values and
// the next byte starts a new text.
// ----------------------------------------------------------------------------
module indentation_rule_checker_top
	import irc_pkg::*;
#(
	parameter int INDENT_WIDTH = 4,
	parameter int MAX_LEVEL    = 63,
	parameter int LINE_BITS    = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	irc_stream_if.sink   item,
	irc_stream_if.source result
);

	localparam int REM_W  = (INDENT_WIDTH > 1) ? $clog2(INDENT_WIDTH) : 1;
	localparam int PREV_W = $clog2(MAX_LEVEL + 1) > 0 ? $clog2(MAX_LEVEL + 1) : 1;
	localparam logic [REM_W-1:0] REM_TOP = REM_W'(INDENT_WIDTH - 1);
	localparam logic [8:0]       LVL_MAX = 9'(MAX_LEVEL);

	// ------------------------------------------------------------------
	// Input stage
	// ------------------------------------------------------------------
	logic     valid_s1;
	in_word_t word_s1;
	logic     advance;

	// final byte needs room in the output register; others always move on
	assign advance    = valid_s1 && (!word_s1.end_of_text || !result.valid || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			word_s1 <= item.data;
		end
	end

	// ------------------------------------------------------------------
	// Scan state
	// ------------------------------------------------------------------
	logic [LINE_BITS-1:0] line_q;
	logic                 colon_q;
	logic [PREV_W-1:0]    prev_q;
	logic [7:0]           spaces_q;   // saturating leading-space count
	logic [REM_W-1:0]     rem_q;      // spaces mod INDENT_WIDTH
	logic [7:0]           lvl_q;      // spaces / INDENT_WIDTH
	scan_mode_t           mode_q;
	logic [1:0]           lat_st_q;
	logic [15:0]          lat_line_q;

	// state after the byte, before any line check
	logic [LINE_BITS-1:0] line_n;
	logic                 colon_n;
	logic [7:0]           spaces_n;
	logic [REM_W-1:0]     rem_n;
	logic [7:0]           lvl_n;
	scan_mode_t           mode_n;
	logic                 leave_lead;  // non-space ends a leading run

	logic [7:0] b;
	assign b = word_s1.text_byte;

	always_comb begin
		line_n     = line_q;
		colon_n    = colon_q;
		spaces_n   = spaces_q;
		rem_n      = rem_q;
		lvl_n      = lvl_q;
		mode_n     = mode_q;
		leave_lead = 1'b0;
		case (mode_q)
			MODE_COMMENT: begin
				if (b == CH_NEWLINE) begin
					mode_n = MODE_LEADING;
				end
			end
			MODE_LEADING: begin
				if (b == CH_SPACE) begin
					if (spaces_q != SPACE_SAT) begin
						spaces_n = spaces_q + 8'd1;
						if (rem_q == REM_TOP) begin
							rem_n = '0;
							lvl_n = lvl_q + 8'd1;
						end else begin
							rem_n = rem_q + REM_W'(1);
						end
					end
				end else if (b == CH_NEWLINE) begin
					mode_n = MODE_LEADING;
				end else begin
					leave_lead = 1'b1;
					colon_n    = (b == CH_COLON);
					mode_n     = (b == CH_HASH) ? MODE_COMMENT : MODE_NORMAL;
				end
			end
			default: begin
				if (b == CH_COLON) begin
					colon_n = 1'b1;
				end else if (b != CH_SPACE && b != CH_NEWLINE) begin
					colon_n = 1'b0;
				end
				if (b == CH_NEWLINE) begin
					mode_n = MODE_LEADING;
				end else if (b == CH_HASH) begin
					mode_n = MODE_COMMENT;
				end
			end
		endcase
		// newline outside a comment body, or ending one
		if (b == CH_NEWLINE) begin
			if (line_q != '1) begin
				line_n = line_q + LINE_BITS'(1);
			end
			spaces_n = '0;
			rem_n    = '0;
			lvl_n    = '0;
		end
	end

	// ------------------------------------------------------------------
	// Line check: either the run just ended by a non-space byte, or the
	// run still open at the final byte
	// ------------------------------------------------------------------
	logic                 chk_en;
	logic [7:0]           chk_spaces;
	logic [REM_W-1:0]     chk_rem;
	logic [7:0]           chk_lvl;
	logic [LINE_BITS-1:0] chk_line;
	logic [1:0]           chk_st;
	logic [PREV_W-1:0]    prev_n;
	logic [1:0]           lat_st_n;
	logic [15:0]          lat_line_n;
	logic [LINE_BITS+15:0] line_ext;
	logic [8:0]           prev_inc;

	assign chk_en     = leave_lead || (word_s1.end_of_text && mode_n == MODE_LEADING);
	assign chk_spaces = leave_lead ? spaces_q : spaces_n;
	assign chk_rem    = leave_lead ? rem_q    : rem_n;
	assign chk_lvl    = leave_lead ? lvl_q    : lvl_n;
	assign chk_line   = leave_lead ? line_q   : line_n;
	assign line_ext   = {16'b0, chk_line};
	assign prev_inc   = 9'(prev_q) + 9'd1;

	always_comb begin
		chk_st     = ST_OK;
		prev_n     = prev_q;
		lat_st_n   = lat_st_q;
		lat_line_n = lat_line_q;
		if (chk_en && lat_st_q == ST_OK) begin
			if (chk_spaces == SPACE_SAT) begin
				chk_st = ST_DEPTH;
			end else if (chk_rem != '0) begin
				chk_st = ST_INDENT;
			end else if ({1'b0, chk_lvl} > LVL_MAX) begin
				chk_st = ST_DEPTH;
			end else if (colon_q ? ({1'b0, chk_lvl} != prev_inc)
			                     : ({1'b0, chk_lvl} > 9'(prev_q))) begin
				chk_st = ST_INDENT;
			end else begin
				prev_n = PREV_W'(chk_lvl);
			end
			if (chk_st != ST_OK) begin
				lat_st_n   = chk_st;
				lat_line_n = line_ext[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q     <= LINE_BITS'(1);
			colon_q    <= 1'b0;
			prev_q     <= '0;
			spaces_q   <= '0;
			rem_q      <= '0;
			lvl_q      <= '0;
			mode_q     <= MODE_NORMAL;
			lat_st_q   <= ST_OK;
			lat_line_q <= '0;
		end else if (advance) begin
			if (word_s1.end_of_text) begin
				// report goes out, next byte starts a new text
				line_q     <= LINE_BITS'(1);
				colon_q    <= 1'b0;
				prev_q     <= '0;
				spaces_q   <= '0;
				rem_q      <= '0;
				lvl_q      <= '0;
				mode_q     <= MODE_NORMAL;
				lat_st_q   <= ST_OK;
				lat_line_q <= '0;
			end else begin
				line_q     <= line_n;
				colon_q    <= colon_n;
				prev_q     <= prev_n;
				spaces_q   <= spaces_n;
				rem_q      <= rem_n;
				lvl_q      <= lvl_n;
				mode_q     <= mode_n;
				lat_st_q   <= lat_st_n;
				lat_line_q <= lat_line_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic      out_valid_q;
	out_word_t out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && word_s1.end_of_text) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.end_of_text) begin
			out_word_q.check_status <= lat_st_n;
			out_word_q.error_line   <= (lat_st_n != ST_OK) ? lat_line_n : 16'd0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_word_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_ok_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.check_status == ST_OK |-> out_word_q.error_line == 16'd0)
		else $error("clean result carries a line number");

	a_reset_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.end_of_text |=> line_q == LINE_BITS'(1) && lat_st_q == ST_OK
			&& mode_q == MODE_NORMAL)
		else $error("scan state not cleared after report");

	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		lat_st_q != ST_OK && !(advance && word_s1.end_of_text)
			|=> $stable(lat_st_q) && $stable(lat_line_q))
		else $error("latched error changed");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= REM_TOP)
		else $error("space remainder out of range");

	a_final_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && word_s1.end_of_text && result.valid && !result.ready |-> !item.ready)
		else $error("final byte would overwrite pending result");

endmodule
